[rtl/adcr_pkg.sv]
// Shared types and constants for the two-wire ADC reader with smoothing.
package adcr_pkg;

    localparam int unsigned RESULT_BITS_DEF = 18;
    localparam int unsigned DATA_BITS       = 24;
    localparam int unsigned SAMPLE_W        = 18;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 20;

    localparam logic [CFG_ADDR_W-1:0] REG_CONFIG_WORD   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_HALF_PERIOD   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_TMO    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_CFG_TMO       = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_FILTER_WEIGHT = 3'd4;

    localparam logic [7:0]  RST_CONFIG_WORD   = 8'h0c;
    localparam logic [9:0]  RST_HALF_PERIOD   = 10'd10;
    localparam logic [19:0] RST_SAMPLE_TMO    = 20'd150000;
    localparam logic [19:0] RST_CFG_TMO       = 20'd750000;
    localparam logic [8:0]  RST_FILTER_WEIGHT = 9'd205;
    localparam logic [8:0]  WEIGHT_FULL       = 9'd256;

    localparam logic [1:0] OP_NONE   = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_WRITE  = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    localparam logic [6:0] CMD_WRITE = 7'h65;
    localparam logic [6:0] CMD_READ  = 7'h56;

    localparam logic [5:0] CLK_DATA_LAST    = 6'd24;
    localparam logic [5:0] CLK_SAMPLE_TOTAL = 6'd27;
    localparam logic [5:0] CLK_CMD_FIRST    = 6'd30;
    localparam logic [5:0] CLK_CMD_LAST     = 6'd36;
    localparam logic [5:0] CLK_TURN         = 6'd37;
    localparam logic [5:0] CLK_CFG_FIRST    = 6'd38;
    localparam logic [5:0] CLK_CFG_LAST     = 6'd45;
    localparam logic [5:0] CLK_CONFIG_TOTAL = 6'd46;

    typedef struct packed {
        logic [7:0]  config_word;
        logic [9:0]  half_ticks;
        logic [19:0] sample_limit;
        logic [19:0] cfg_limit;
        logic [8:0]  weight;
    } t_cfg;

endpackage

[rtl/adcr_regs.sv]
// Configuration registers with the effective values the sequencer uses.
module adcr_regs
    import adcr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                  o_cfg
);

    logic [7:0]  r_config_word;
    logic [9:0]  r_half_period;
    logic [19:0] r_sample_tmo;
    logic [19:0] r_cfg_tmo;
    logic [8:0]  r_weight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_config_word <= RST_CONFIG_WORD;
            r_half_period <= RST_HALF_PERIOD;
            r_sample_tmo  <= RST_SAMPLE_TMO;
            r_cfg_tmo     <= RST_CFG_TMO;
            r_weight      <= RST_FILTER_WEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_CONFIG_WORD:   r_config_word <= i_cfg_wdata[7:0];
                REG_HALF_PERIOD:   r_half_period <= i_cfg_wdata[9:0];
                REG_SAMPLE_TMO:    r_sample_tmo  <= i_cfg_wdata[19:0];
                REG_CFG_TMO:       r_cfg_tmo     <= i_cfg_wdata[19:0];
                REG_FILTER_WEIGHT: r_weight      <= i_cfg_wdata[8:0];
                default: ;
            endcase
        end
    end

    // A zero period or timeout behaves as one; a weight above full scale saturates.
    always_comb begin
        o_cfg.config_word  = r_config_word;
        o_cfg.half_ticks   = (r_half_period == '0) ? 10'd1 : r_half_period;
        o_cfg.sample_limit = (r_sample_tmo == '0) ? 20'd1 : r_sample_tmo;
        o_cfg.cfg_limit    = (r_cfg_tmo == '0) ? 20'd1 : r_cfg_tmo;
        o_cfg.weight       = (r_weight > WEIGHT_FULL) ? WEIGHT_FULL : r_weight;
    end

endmodule

[rtl/adcr_filter.sv]
// First-order low-pass update of the smoothed sample.
module adcr_filter
    import adcr_pkg::*;
(
    input  logic [SAMPLE_W-1:0] i_old,
    input  logic [SAMPLE_W-1:0] i_new,
    input  logic [8:0]          i_weight,
    output logic [SAMPLE_W-1:0] o_filtered
);

    // old*w + new*(256-w) is rewritten as new*256 + (old-new)*w, one multiplier.
    logic signed [SAMPLE_W:0]   diff;
    logic signed [SAMPLE_W+9:0] prod;
    logic signed [SAMPLE_W+9:0] acc;

    assign diff       = $signed({1'b0, i_old}) - $signed({1'b0, i_new});
    assign prod       = diff * $signed({1'b0, i_weight});
    assign acc        = $signed({2'b00, i_new, 8'h00}) + prod;
    assign o_filtered = acc[SAMPLE_W+7:8];

endmodule

[rtl/adcr_seq.sv]
// Pin sequencer: one tick per accepted word, with registered pin and status results.
module adcr_seq
    import adcr_pkg::*;
#(
    parameter int unsigned RESULT_BITS = RESULT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic [1:0]          i_req_type,
    input  logic                i_dout_level,
    input  t_cfg                i_cfg,
    output logic                o_sclk_level,
    output logic                o_dout_drive,
    output logic                o_dout_enable,
    output logic                o_busy_res,
    output logic                o_done_res,
    output logic                o_status,
    output logic [SAMPLE_W-1:0] o_raw_sample,
    output logic [SAMPLE_W-1:0] o_smoothed_sample,
    output logic [7:0]          o_config_readback
);

    localparam int unsigned RAW_SHIFT = DATA_BITS - RESULT_BITS;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PARKED,
        PH_RELEASED,
        PH_WAIT,
        PH_HIGH,
        PH_LOW
    } t_phase;

    t_phase                r_phase, n_phase;
    logic [1:0]            r_op, n_op;
    logic [5:0]            r_cc, n_cc;
    logic [9:0]            r_ht, n_ht;
    logic [19:0]           r_wc, n_wc;
    logic [DATA_BITS-1:0]  r_shift, n_shift;
    logic [SAMPLE_W-1:0]   r_last, n_last;
    logic [SAMPLE_W-1:0]   r_filt, n_filt;
    logic [7:0]            r_rb, n_rb;
    logic                  r_sclk, n_sclk;
    logic                  r_drive, n_drive;
    logic                  r_enable, n_enable;
    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic                  r_status, n_status;

    logic [9:0]            ht_inc;
    logic [19:0]           wc_inc;
    logic [19:0]           limit;
    logic [5:0]            total;
    logic [DATA_BITS-1:0]  shifted;
    logic [SAMPLE_W-1:0]   sample_raw;
    logic [SAMPLE_W-1:0]   filt_new;
    logic [6:0]            cmd;
    logic [5:0]            cmd_idx;
    logic [5:0]            cfg_idx;

    assign ht_inc     = r_ht + 10'd1;
    assign wc_inc     = r_wc + 20'd1;
    assign limit      = (r_op == OP_SAMPLE) ? i_cfg.sample_limit : i_cfg.cfg_limit;
    assign total      = (r_op == OP_SAMPLE) ? CLK_SAMPLE_TOTAL : CLK_CONFIG_TOTAL;
    assign shifted    = r_shift >> RAW_SHIFT;
    assign sample_raw = shifted[SAMPLE_W-1:0];

    adcr_filter u_filter (
        .i_old      (r_filt),
        .i_new      (sample_raw),
        .i_weight   (i_cfg.weight),
        .o_filtered (filt_new)
    );

    always_comb begin
        n_phase = r_phase;
        n_op    = r_op;
        n_cc    = r_cc;
        n_ht    = r_ht;
        n_wc    = r_wc;
        n_shift = r_shift;
        n_last  = r_last;
        n_filt  = r_filt;
        n_rb    = r_rb;
        n_done  = 1'b0;
        unique case (r_phase)
            PH_IDLE, PH_PARKED, PH_RELEASED: begin
                if (i_req_type != OP_NONE) begin
                    n_op    = i_req_type;
                    n_phase = PH_WAIT;
                    n_cc    = '0;
                    n_ht    = '0;
                    n_wc    = '0;
                    n_shift = '0;
                end
            end
            PH_WAIT: begin
                if (!i_dout_level) begin
                    n_phase = PH_HIGH;
                    n_cc    = 6'd1;
                    n_ht    = '0;
                end else begin
                    n_wc = wc_inc;
                    if (wc_inc >= limit) begin
                        if (r_op == OP_SAMPLE) begin
                            n_last = '0;
                        end
                        n_phase = PH_PARKED;
                        n_done  = 1'b1;
                    end
                end
            end
            PH_HIGH: begin
                n_ht = ht_inc;
                if (ht_inc >= i_cfg.half_ticks) begin
                    if (r_op == OP_SAMPLE && r_cc <= CLK_DATA_LAST) begin
                        n_shift = {r_shift[DATA_BITS-2:0], i_dout_level};
                    end
                    n_phase = PH_LOW;
                    n_ht    = '0;
                end
            end
            PH_LOW: begin
                n_ht = ht_inc;
                if (ht_inc >= i_cfg.half_ticks) begin
                    if (r_op == OP_READ && r_cc >= CLK_CFG_FIRST && r_cc <= CLK_CFG_LAST) begin
                        n_shift = {r_shift[DATA_BITS-2:0], i_dout_level};
                    end
                    n_ht = '0;
                    if (r_cc >= total) begin
                        n_done = 1'b1;
                        if (r_op == OP_SAMPLE) begin
                            n_last = sample_raw;
                            if (sample_raw != '0) begin
                                n_filt = filt_new;
                            end
                            n_phase = PH_RELEASED;
                        end else begin
                            if (r_op == OP_READ) begin
                                n_rb = r_shift[7:0];
                            end
                            n_phase = PH_IDLE;
                        end
                    end else begin
                        n_cc    = r_cc + 6'd1;
                        n_phase = PH_HIGH;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // Pin levels follow the state after this tick's update.
    assign cmd     = (n_op == OP_WRITE) ? CMD_WRITE : CMD_READ;
    assign cmd_idx = CLK_CMD_LAST - n_cc;
    assign cfg_idx = CLK_CFG_LAST - n_cc;

    always_comb begin
        n_drive  = 1'b0;
        n_enable = 1'b0;
        if (n_phase == PH_PARKED || n_phase == PH_RELEASED) begin
            n_drive  = 1'b1;
            n_enable = 1'b1;
        end else if ((n_phase == PH_HIGH || n_phase == PH_LOW) && n_op != OP_SAMPLE) begin
            if (n_cc >= CLK_CMD_FIRST && n_cc <= CLK_CMD_LAST) begin
                n_drive  = cmd[cmd_idx[2:0]];
                n_enable = 1'b1;
            end else if (n_cc == CLK_TURN) begin
                n_drive  = 1'b1;
                n_enable = 1'b1;
            end else if (n_cc >= CLK_CFG_FIRST && n_cc <= CLK_CFG_LAST && n_op == OP_WRITE) begin
                n_drive  = i_cfg.config_word[cfg_idx[2:0]];
                n_enable = 1'b1;
            end
        end
    end

    assign n_sclk   = (n_phase == PH_HIGH) || (n_phase == PH_PARKED);
    assign n_busy   = (n_phase == PH_WAIT) || (n_phase == PH_HIGH) || (n_phase == PH_LOW);
    assign n_status = (n_phase == PH_PARKED);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_op     <= OP_NONE;
            r_cc     <= '0;
            r_ht     <= '0;
            r_wc     <= '0;
            r_shift  <= '0;
            r_last   <= '0;
            r_filt   <= '0;
            r_rb     <= '0;
            r_sclk   <= 1'b0;
            r_drive  <= 1'b0;
            r_enable <= 1'b0;
            r_busy   <= 1'b0;
            r_done   <= 1'b0;
            r_status <= 1'b0;
        end else if (i_adv) begin
            r_phase  <= n_phase;
            r_op     <= n_op;
            r_cc     <= n_cc;
            r_ht     <= n_ht;
            r_wc     <= n_wc;
            r_shift  <= n_shift;
            r_last   <= n_last;
            r_filt   <= n_filt;
            r_rb     <= n_rb;
            r_sclk   <= n_sclk;
            r_drive  <= n_drive;
            r_enable <= n_enable;
            r_busy   <= n_busy;
            r_done   <= n_done;
            r_status <= n_status;
        end
    end

    assign o_sclk_level      = r_sclk;
    assign o_dout_drive      = r_drive;
    assign o_dout_enable     = r_enable;
    assign o_busy_res        = r_busy;
    assign o_done_res        = r_done;
    assign o_status          = r_status;
    assign o_raw_sample      = r_last;
    assign o_smoothed_sample = r_filt;
    assign o_config_readback = r_rb;

endmodule

[rtl/adc_two_wire_reader_with_smoothing.sv]
// Top level of the two-wire ADC reader with sample smoothing.
//
// Each input word is one timing tick: a request code and the sampled level
// of the data pin. Each accepted word yields exactly one result word that
// carries the serial clock and data pin levels to drive, busy, done and
// status flags, the latest raw sample, the smoothed sample and the control
// byte last read back from the converter.
// The result of a word appears on the output register in the cycle after
// it is accepted. Throughput is one word per cycle while the receiver
// does not stall, set by the single registered sequencer update per tick.
// The input stalls only while a result is held and the receiver stalls;
// a held result is taken and a new word accepted in the same cycle.
// Configuration writes take effect at once; the user must make them while idle, as the block does not enforce it.
// Synchronous active-low reset returns the sequencer to idle, clears all
// samples and loads the default configuration; no result is pending.
module adc_two_wire_reader_with_smoothing
    import adcr_pkg::*;
#(
    parameter int unsigned RESULT_BITS = RESULT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [1:0]            i_req_type,
    input  logic                  i_dout_level,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_sclk_level,
    output logic                  o_dout_drive,
    output logic                  o_dout_enable,
    output logic                  o_busy_res,
    output logic                  o_done_res,
    output logic                  o_status,
    output logic [SAMPLE_W-1:0]   o_raw_sample,
    output logic [SAMPLE_W-1:0]   o_smoothed_sample,
    output logic [7:0]            o_config_readback
);

    t_cfg cfg;
    logic accept;
    logic r_out_valid;

    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    adcr_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    adcr_seq #(
        .RESULT_BITS (RESULT_BITS)
    ) u_seq (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_adv             (accept),
        .i_req_type        (i_req_type),
        .i_dout_level      (i_dout_level),
        .i_cfg             (cfg),
        .o_sclk_level      (o_sclk_level),
        .o_dout_drive      (o_dout_drive),
        .o_dout_enable     (o_dout_enable),
        .o_busy_res        (o_busy_res),
        .o_done_res        (o_done_res),
        .o_status          (o_status),
        .o_raw_sample      (o_raw_sample),
        .o_smoothed_sample (o_smoothed_sample),
        .o_config_readback (o_config_readback)
    );

endmodule

[rtl/adcr_checker.sv]
// Port-level assertions for the two-wire ADC reader, bound to the top level.
module adcr_checker
    import adcr_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_valid,
    input logic                i_stall,
    input logic                o_sclk_level,
    input logic                o_dout_drive,
    input logic                o_dout_enable,
    input logic                o_busy_res,
    input logic                o_done_res,
    input logic                o_status,
    input logic [SAMPLE_W-1:0] o_raw_sample
);

    // A finished operation is never reported as still running.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_done_res |-> !o_busy_res)
        else $error("done word reports busy");

    // After a timeout both pins are held high with the data pin driven.
    a_parked_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_sclk_level && o_dout_enable && o_dout_drive && !o_busy_res)
        else $error("timeout word does not park the pins");

    // The data level is low whenever the pin is released.
    a_released_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_dout_enable |-> !o_dout_drive)
        else $error("data level set while pin released");

    // A stalled result word holds.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_raw_sample) && $stable(o_done_res))
        else $error("stalled result word changed");

endmodule

bind adc_two_wire_reader_with_smoothing adcr_checker u_adcr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_sclk_level  (o_sclk_level),
    .o_dout_drive  (o_dout_drive),
    .o_dout_enable (o_dout_enable),
    .o_busy_res    (o_busy_res),
    .o_done_res    (o_done_res),
    .o_status      (o_status),
    .o_raw_sample  (o_raw_sample)
);
